/* design/laplacian_high_pass_3x3_macros.svh */
// assertion macros for the laplacian high-pass design file
`ifndef LAPLACIAN_HIGH_PASS_3X3_MACROS_SVH
`define LAPLACIAN_HIGH_PASS_3X3_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define LHP3_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define LHP3_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

/* design/lhp3_pkg.sv */
// package with constants and types for the laplacian high-pass filter
`default_nettype none
package lhp3_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	// register index, taken from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// floor(x / 3) = (x * 683) >> 11 for x up to 765
	localparam logic [9:0] GRAY_RECIP = 10'd683;
	localparam int         GRAY_SHIFT = 11;

	localparam int OQ_DEPTH = 8;

	typedef struct packed {
		logic [7:0] pix;
		logic       last;
		logic       fend;
	} result_t;

endpackage
`default_nettype wire

/* design/laplacian_high_pass_3x3.sv */
// laplacian 3x3 high-pass filter over a raster rgb pixel stream, top level
`default_nettype none
`include "laplacian_high_pass_3x3_macros.svh"
// a result passes through the stage-1 registers and then the result queue before it reaches the output port
// throughput: one item per cycle while in_stall is low; on the last row each item gives two results,
// so the single output port sets the pace there and holds the input back through in_stall
// the gray line store is one synchronous memory, one read and one write a cycle
// reset: dimensions 640 x 480, counters zero, line store undefined until written
// (no clearing pass), result queue empty
module laplacian_high_pass_3x3
	import lhp3_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb-style configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       filtered_pixel,
	output logic             last_of_input,
	output logic             frame_end
);

	// column index and effective width
	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WEW  = $clog2(MAX_WIDTH + 1);
	localparam int WCMP = (WEW > WIDTH_REG_W) ? WEW : WIDTH_REG_W;
	// row index and effective height
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int HEW  = $clog2(MAX_HEIGHT + 1);
	localparam int HCMP = (HEW > HEIGHT_REG_W) ? HEW : HEIGHT_REG_W;
	// result queue
	localparam int QPW  = $clog2(OQ_DEPTH);
	localparam int QCW  = $clog2(OQ_DEPTH + 1);

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [WIDTH_REG_W-1:0]  image_width_q;
	logic [HEIGHT_REG_W-1:0] image_height_q;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[WIDTH_REG_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= pwdata[HEIGHT_REG_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH: begin
				prdata = 32'(image_width_q);
			end
			REG_IMAGE_HEIGHT: begin
				prdata = 32'(image_height_q);
			end
		endcase
	end

	// effective dimensions saturate to 3..MAX; only the last index is needed
	logic [WCMP-1:0] w_reg_x;
	logic [HCMP-1:0] h_reg_x;
	logic [WEW-1:0]  eff_w;
	logic [HEW-1:0]  eff_h;
	logic [AW-1:0]   w_last;
	logic [RW-1:0]   h_last;

	always_comb begin
		w_reg_x = WCMP'(image_width_q);
		h_reg_x = HCMP'(image_height_q);
		priority if (w_reg_x < WCMP'(3)) begin
			eff_w = WEW'(3);
		end else if (w_reg_x > WCMP'(MAX_WIDTH)) begin
			eff_w = WEW'(MAX_WIDTH);
		end else begin
			eff_w = WEW'(w_reg_x);
		end
		priority if (h_reg_x < HCMP'(3)) begin
			eff_h = HEW'(3);
		end else if (h_reg_x > HCMP'(MAX_HEIGHT)) begin
			eff_h = HEW'(MAX_HEIGHT);
		end else begin
			eff_h = HEW'(h_reg_x);
		end
		w_last = AW'(eff_w - WEW'(1));
		h_last = RW'(eff_h - HEW'(1));
	end

	// ---------------------------------------------------------------
	// handshakes and raster position
	// ---------------------------------------------------------------
	logic             in_accept;
	logic             out_pop;
	logic [AW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             col_is_last;
	logic [AW-1:0]    pf_addr;

	logic             valid_s1;
	logic [QCW-1:0]   oq_cnt_q;

	// reserve room for two results of every item in flight plus the new one
	assign in_stall  = ((QCW+1)'(oq_cnt_q) + (valid_s1 ? (QCW+1)'(2) : (QCW+1)'(0)))
	                   > (QCW+1)'(OQ_DEPTH - 2);
	assign in_accept = in_valid & ~in_stall;
	assign out_valid = (oq_cnt_q != '0);
	assign out_pop   = out_valid & ~out_stall;

	assign col_is_last = (col_q == w_last);
	// the entry one column ahead is fetched with each item; at the row end
	// this wraps to column 0 for the first item of the next row
	assign pf_addr = col_is_last ? '0 : col_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			// any register write restarts the frame
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (col_is_last) begin
				col_q <= '0;
				row_q <= (row_q == h_last) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// gray by reciprocal multiply, exact for sums up to 765
	logic [9:0]  rgb_sum;
	logic [19:0] gray_prod;
	logic [7:0]  gray_in;

	assign rgb_sum   = 10'(red) + 10'(green) + 10'(blue);
	assign gray_prod = 20'(rgb_sum) * 20'(GRAY_RECIP);
	assign gray_in   = gray_prod[GRAY_SHIFT+7:GRAY_SHIFT];

	// ---------------------------------------------------------------
	// line store: entry = {older, recent} gray of one column
	// ---------------------------------------------------------------
	logic [15:0] line_mem [MAX_WIDTH];
	logic [15:0] rd_q;    // entry of the column after the item in stage 1
	logic [15:0] win_q;   // entry of the item's own column
	logic [7:0]  prev_center_q;

	logic [7:0]    gray_s1;
	logic [AW-1:0] col_s1;
	logic          emit_s1;
	logic          interior_s1;
	logic          last_row_s1;
	logic          last_col_s1;

	// write back in stage 1 never hits the column being fetched (width >= 3)
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[col_s1] <= {win_q[7:0], gray_s1};
		end
		if (in_accept) begin
			rd_q <= line_mem[pf_addr];
		end
	end

	// the previous fetch is the current column's entry
	always_ff @(posedge clk) begin
		if (in_accept) begin
			win_q       <= rd_q;
			gray_s1     <= gray_in;
			col_s1      <= col_q;
			emit_s1     <= (row_q != '0);
			interior_s1 <= (row_q > RW'(1)) && (col_q != '0) && !col_is_last;
			last_row_s1 <= (row_q == h_last);
			last_col_s1 <= col_is_last;
		end
		// left neighbour is the centre of the previous column in the row
		if (valid_s1) begin
			prev_center_q <= win_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: laplacian and clamp
	// ---------------------------------------------------------------
	logic [7:0]  up_px;
	logic [7:0]  center_px;
	logic [7:0]  right_px;
	logic [11:0] lap;
	logic [7:0]  lap_clamped;
	result_t     res_a;
	result_t     res_b;

	assign up_px     = win_q[15:8];
	assign center_px = win_q[7:0];
	assign right_px  = rd_q[7:0];

	always_comb begin
		lap = {2'b00, center_px, 2'b00} - 12'(up_px) - 12'(gray_s1)
		      - 12'(prev_center_q) - 12'(right_px);
		priority if (lap[11]) begin
			lap_clamped = 8'd0;
		end else if (lap[10:8] != 3'b000) begin
			lap_clamped = 8'd255;
		end else begin
			lap_clamped = lap[7:0];
		end
		res_a.pix  = interior_s1 ? lap_clamped : 8'd0;
		res_a.last = ~last_row_s1;
		res_a.fend = 1'b0;
		// the last row also gives a border zero for itself
		res_b.pix  = 8'd0;
		res_b.last = 1'b1;
		res_b.fend = last_col_s1;
	end

	// ---------------------------------------------------------------
	// result queue
	// ---------------------------------------------------------------
	result_t        oq_q [OQ_DEPTH];
	logic [QPW-1:0] oq_wr_q;
	logic [QPW-1:0] oq_rd_q;
	logic           push_a;
	logic           push_b;

	assign push_a = valid_s1 & emit_s1;
	assign push_b = push_a & last_row_s1;

	always_ff @(posedge clk) begin
		if (push_a) begin
			oq_q[oq_wr_q] <= res_a;
		end
		if (push_b) begin
			oq_q[oq_wr_q + QPW'(1)] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			oq_wr_q  <= oq_wr_q + QPW'(push_a) + QPW'(push_b);
			oq_rd_q  <= oq_rd_q + QPW'(out_pop);
			oq_cnt_q <= oq_cnt_q + QCW'(push_a) + QCW'(push_b) - QCW'(out_pop);
		end
	end

	assign filtered_pixel = oq_q[oq_rd_q].pix;
	assign last_of_input  = oq_q[oq_rd_q].last;
	assign frame_end      = oq_q[oq_rd_q].fend;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`LHP3_ASSERT(a_oq_bound, oq_cnt_q <= QCW'(OQ_DEPTH), "result queue overflow")
	`LHP3_ASSERT(a_col_range, col_q <= w_last, "column beyond image width")
	`LHP3_ASSERT_NEXT(a_accept_s1, in_accept, valid_s1, "accepted item missing in stage 1")
	`LHP3_ASSERT(a_fend_last, !(out_valid && frame_end) || last_of_input,
		"frame end on a result that is not last of its item")

endmodule
`default_nettype wire

/* tb/laplacian_high_pass_3x3_tb.sv */
// self-checking testbench for the laplacian high-pass filter, predicting each result in step
`timescale 1ns / 1ps

module laplacian_high_pass_3x3_tb;
	import lhp3_pkg::*;

	// quiet cycles allowed after the last expected result before touching registers
	localparam int SETTLE_CYCLES = 10;
	// hard stop, far beyond the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 30;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  filtered_pixel;
	logic        last_of_input;
	logic        frame_end;

	laplacian_high_pass_3x3 DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_pixel (filtered_pixel),
		.last_of_input  (last_of_input),
		.frame_end      (frame_end)
	);

	// 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// predictor state: our own copy of the registers, counters and the two
	// gray line stores; the stores start at zero, which never shows in a
	// result because interior pixels only read entries written this frame
	// ------------------------------------------------------------------
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	logic [7:0]              older_gray  [MAX_WIDTH_DEF];
	logic [7:0]              recent_gray [MAX_WIDTH_DEF];
	int                      col_count;
	int                      row_count;

	// results still owed by the block, oldest first
	result_t laplacian_results [$];

	int mismatches;
	int cycle_count;

	// sender burst shaping
	int burst_left;
	bit gaps_on;

	// receiver stall pattern and long hold-off
	int hold_request;
	int hold_left;
	int stall_mode;
	int mode_left;
	int pattern_phase;
	bit stall_now;

	result_t want_res;

	// one line per mismatch, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// works out the results one accepted pixel causes and queues them
	task automatic compute_laplacian(input logic [7:0] r8, input logic [7:0] g8,
			input logic [7:0] b8);
		int w, h, c, rw, gray, up_px, mid_px, right_px, left_px, sum;
		bit last_row;
		w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
		h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
		c = (col_count >= w) ? 0 : col_count;
		rw = (row_count >= h) ? 0 : row_count;
		gray = (int'(r8) + int'(g8) + int'(b8)) / 3;

		// neighbours of the pixel one row up; left has already moved into the older store
		up_px = older_gray[c];
		mid_px = recent_gray[c];
		right_px = (c + 1 < w) ? recent_gray[c + 1] : 0;
		left_px = (c > 0) ? older_gray[c - 1] : 0;
		older_gray[c] = 8'(mid_px);
		recent_gray[c] = 8'(gray);

		if (rw >= 1) begin
			sum = 0;
			last_row = (rw == h - 1);
			if (rw >= 2 && c >= 1 && c + 1 < w) begin
				sum = 4 * mid_px - up_px - gray - left_px - right_px;
				if (sum < 0)
					sum = 0;
				if (sum > 255)
					sum = 255;
			end
			laplacian_results.push_back('{pix: 8'(sum), last: !last_row, fend: 1'b0});
			// last row: a border zero for the pixel just taken in
			if (last_row)
				laplacian_results.push_back('{pix: 8'd0, last: 1'b1, fend: (c == w - 1)});
		end

		c++;
		if (c >= w) begin
			c = 0;
			rw++;
			if (rw >= h)
				rw = 0;
		end
		col_count = c;
		row_count = rw;
	endtask

	// ------------------------------------------------------------------
	// result checker: every accepted result against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (laplacian_results.size() == 0) begin
				report_mismatch("unexpected result, pixel", filtered_pixel, -1);
			end else begin
				want_res = laplacian_results.pop_front();
				if (filtered_pixel !== want_res.pix)
					report_mismatch("filtered_pixel", filtered_pixel, want_res.pix);
				if (last_of_input !== want_res.last)
					report_mismatch("last_of_input", last_of_input, want_res.last);
				if (frame_end !== want_res.fend)
					report_mismatch("frame_end", frame_end, want_res.fend);
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: stall pattern that changes mode now and then, plus a long
	// hold-off on request that lets the block fill and push back on its input
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(16, 200);
		end
		mode_left--;
		pattern_phase++;
		if (hold_left > 0) begin
			hold_left--;
			stall_now = 1'b1;
		end else begin
			case (stall_mode)
				0: stall_now = 1'b0;
				1: stall_now = ($urandom_range(0, 7) == 0);
				2: stall_now = $urandom_range(0, 1);
				default: stall_now = (pattern_phase % 3 == 0);
			endcase
		end
		out_stall <= stall_now;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("laplacian_high_pass_3x3 verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// offers one pixel, sometimes after a random gap when a burst runs out and gaps are on, and predicts on acceptance
	task automatic push_pixel(input logic [7:0] r8, input logic [7:0] g8, input logic [7:0] b8);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on && $urandom_range(0, 2) != 0)
				gap = $urandom_range(1, 6);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		red <= r8;
		green <= g8;
		blue <= b8;
		do @(posedge clk); while (in_stall);
		compute_laplacian(r8, g8, b8);
	endtask

	// components lean towards the rails so both clamps get hit often
	function automatic logic [7:0] random_component();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic stream_random(input int count);
		for (int i = 0; i < count; i++)
			push_pixel(random_component(), random_component(), random_component());
	endtask

	task automatic push_rgb(input logic [23:0] rgb);
		push_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
	endtask

	task automatic end_stream();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// every owed result back, then a quiet spell for anything still in flight
	task automatic wait_quiet();
		while (laplacian_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb read of one register against the value it should hold
	task automatic read_register(input logic idx, input logic [31:0] expected);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== expected)
			report_mismatch(idx == REG_IMAGE_WIDTH ? "image_width read" :
				"image_height read", prdata, expected);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// apb write then read-back of one register; a write restarts the frame
	task automatic write_register(input logic idx, input logic [31:0] value);
		logic [31:0] stored;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = value[WIDTH_REG_W-1:0];
			stored = 32'(width_reg);
		end else begin
			height_reg = value[HEIGHT_REG_W-1:0];
			stored = 32'(height_reg);
		end
		col_count = 0;
		row_count = 0;

		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored)
			report_mismatch(idx == REG_IMAGE_WIDTH ? "image_width read-back" :
				"image_height read-back", prdata, stored);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_frame_size(input logic [31:0] width_val, input logic [31:0] height_val);
		// order varies, the result must not
		if ($urandom_range(0, 1)) begin
			write_register(REG_IMAGE_WIDTH, width_val);
			write_register(REG_IMAGE_HEIGHT, height_val);
		end else begin
			write_register(REG_IMAGE_HEIGHT, height_val);
			write_register(REG_IMAGE_WIDTH, width_val);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset dimensions read back; the start of the first row gives nothing
	task automatic test_reset_size();
		read_register(REG_IMAGE_WIDTH, 32'(WIDTH_RESET));
		read_register(REG_IMAGE_HEIGHT, 32'(HEIGHT_RESET));
		stream_random(30);
		end_stream();
		wait_quiet();
	endtask

	// hand-built frames: both clamps, ignored corners, truncated gray
	task automatic test_directed_frames();
		// centre white on black, white corners that the cross kernel must ignore
		logic [23:0] bright_centre [9] = '{
			24'hffffff, 24'h000000, 24'hffffff,
			24'h000000, 24'hffffff, 24'h000000,
			24'hffffff, 24'h000000, 24'hffffff};
		// left interior pixel clamps low; right one is small and unclamped,
		// only right if gray is the truncated mean
		logic [23:0] four_wide [12] = '{
			24'h123456, 24'hffffff, 24'h010100, 24'hff00ff,
			24'hfffffe, 24'h000000, 24'h020201, 24'h010101,
			24'h00ff00, 24'hfffffe, 24'h000101, 24'h0000ff};
		// width written as zero saturates to 3; height bits above the register drop away
		set_frame_size(32'h0000_0000, 32'hffff_e003);
		foreach (bright_centre[i])
			push_rgb(bright_centre[i]);
		end_stream();
		wait_quiet();
		// height two saturates to 3
		set_frame_size(32'd4, 32'd2);
		foreach (four_wide[i])
			push_rgb(four_wide[i]);
		end_stream();
		wait_quiet();
	endtask

	// widest setting, saturating to the line store: only the start of its first row
	task automatic test_max_width();
		set_frame_size(32'h0000_0fff, 32'd3);
		stream_random(24);
		end_stream();
		wait_quiet();
	endtask

	// tallest frame: only its first rows, the next write restarts it anyway
	task automatic test_max_height();
		set_frame_size(32'd3, 32'h0000_1fff);
		stream_random(15);
		end_stream();
		wait_quiet();
	endtask

	// small frames back to back, some cut short by a register write
	task automatic test_random_frames();
		int sent, w, h, n;
		logic [31:0] width_val, height_val;
		sent = 0;
		while (sent < 300) begin
			width_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			height_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
			w = (width_val < 3) ? 3 : width_val;
			h = (height_val < 3) ? 3 : height_val;
			set_frame_size(width_val, height_val);
			n = $urandom_range(1, 2) * w * h;
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(1, w * h - 1);
			stream_random(n);
			sent += n;
			end_stream();
			wait_quiet();
		end
	endtask

	// receiver holds off while pixels keep coming: the block has to stall its input
	task automatic test_output_hold_off();
		gaps_on = 1'b0;
		set_frame_size(32'd6, 32'd8);
		stream_random(14);
		hold_request = 300;
		stream_random(34);
		gaps_on = 1'b1;
		end_stream();
		wait_quiet();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		out_stall = 1'b0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		col_count = 0;
		row_count = 0;
		foreach (older_gray[i]) begin
			older_gray[i] = 8'd0;
			recent_gray[i] = 8'd0;
		end
		mismatches = 0;
		cycle_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_request = 0;
		hold_left = 0;
		stall_mode = 0;
		mode_left = 0;
		pattern_phase = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_size();
		test_directed_frames();
		test_max_width();
		test_max_height();
		test_random_frames();
		test_output_hold_off();

		if (mismatches == 0 && laplacian_results.size() == 0)
			$display("laplacian_high_pass_3x3 verification clean");
		else
			$display("laplacian_high_pass_3x3 verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/lhp3_pkg.sv
design/laplacian_high_pass_3x3.sv
tb/laplacian_high_pass_3x3_tb.sv
